FILE: rtl/rcpwm_pkg.sv
// Shared types and constants for the RC PWM input to drive output block.
package rcpwm_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_CAPTURE_WRAP = 3'd0,
        CFG_ACCEL_OFFSET = 3'd1,
        CFG_STEER_OFFSET = 3'd2,
        CFG_DEADBAND     = 3'd3,
        CFG_ACCEL_LIMIT  = 3'd4,
        CFG_STEER_LIMIT  = 3'd5,
        CFG_TIMEOUT_MS   = 3'd6,
        CFG_STEER_TRIM   = 3'd7
    } cfg_idx_t;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int COUNT_W    = 16;  // width of the capture_count field
    localparam int DIFF_W     = 19;  // signed width for wrapped difference and pulse width
    localparam int VAL_W      = 12;  // signed per-mille channel value

    localparam logic [0:0] REQ_CAPTURE = 1'b0;
    localparam logic [0:0] REQ_TICK    = 1'b1;

    localparam logic signed [DIFF_W-1:0] WIDTH_LOW  = 19'sd850;
    localparam logic signed [DIFF_W-1:0] WIDTH_HIGH = 19'sd2150;
    localparam logic signed [DIFF_W-1:0] WIDTH_MID  = 19'sd1500;

    typedef struct packed {
        logic        [15:0] capture_wrap;
        logic signed [10:0] accel_offset;
        logic signed [10:0] steer_offset;
        logic        [9:0]  deadband;
        logic        [9:0]  accel_limit;
        logic        [9:0]  steer_limit;
        logic        [9:0]  timeout_ms;
        logic        [9:0]  steer_trim;
    } cfg_t;

    // Decoded channel values after the timeout check
    typedef struct packed {
        logic signed [VAL_W-1:0] accel;
        logic signed [VAL_W-1:0] steer;
        logic                    accepted;
    } chan_t;

    // Result word fields
    typedef struct packed {
        logic        capture_accepted;
        logic [10:0] steer_compare;
        logic        drive_reverse;
        logic [9:0]  drive_duty;
    } res_t;

endpackage

FILE: rtl/rcpwm_decode.sv
// Capture decoder: per-channel previous count, decoded value and age state.
module rcpwm_decode #(
    parameter int COUNTER_BITS = 16,
    parameter int AGE_BITS     = 11
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  take,
    input  logic                  req_type,
    input  logic                  channel,
    input  logic [15:0]           capture_count,
    input  rcpwm_pkg::cfg_t       cfg,
    output rcpwm_pkg::chan_t      chan_next
);

    localparam int CNT_W = (COUNTER_BITS < rcpwm_pkg::COUNT_W) ? COUNTER_BITS
                                                                 : rcpwm_pkg::COUNT_W;
    localparam int CMP_W = (AGE_BITS > 10) ? AGE_BITS : 10;
    localparam int DW    = rcpwm_pkg::DIFF_W;
    localparam int VW    = rcpwm_pkg::VAL_W;

    logic [CNT_W-1:0]           prev_reg  [2];
    logic [CNT_W-1:0]           prev_next [2];
    logic signed [VW-1:0]       value_reg [2];
    logic signed [VW-1:0]       value_next[2];
    logic [AGE_BITS-1:0]        age_reg   [2];
    logic [AGE_BITS-1:0]        age_next  [2];

    logic [CNT_W-1:0]           cnt;
    logic [CNT_W-1:0]           prev_sel;
    logic signed [DW-1:0]       diff;
    logic signed [DW-1:0]       width;
    logic signed [DW-1:0]       centered;
    logic signed [10:0]         offset_sel;
    logic                       in_window;
    logic signed [VW-1:0]       value_raw;
    logic [VW-1:0]              value_mag;
    logic signed [VW-1:0]       value_db;

    assign cnt        = capture_count[CNT_W-1:0];
    assign prev_sel   = prev_reg[channel];
    assign offset_sel = channel ? cfg.steer_offset : cfg.accel_offset;

    always_comb
    begin
        if (cnt >= prev_sel)
        begin
            diff = DW'(cnt - prev_sel);
        end
        else
        begin
            diff = $signed(DW'(cfg.capture_wrap)) - $signed(DW'(prev_sel))
                   + $signed(DW'(cnt));
        end
        width     = diff - DW'(offset_sel);
        in_window = (width > rcpwm_pkg::WIDTH_LOW) && (width < rcpwm_pkg::WIDTH_HIGH);
        centered  = width - rcpwm_pkg::WIDTH_MID;
        value_raw = {centered[VW-2:0], 1'b0};
        value_mag = value_raw[VW-1] ? VW'(-value_raw) : VW'(value_raw);
        value_db  = (value_mag < VW'(cfg.deadband)) ? '0 : value_raw;
    end

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            prev_next[i]  = prev_reg[i];
            value_next[i] = value_reg[i];
            age_next[i]   = age_reg[i];
        end
        chan_next.accepted = 1'b0;
        if (req_type == rcpwm_pkg::REQ_TICK)
        begin
            for (int i = 0; i < 2; i++)
            begin
                if (age_reg[i] != '1)
                begin
                    age_next[i] = age_reg[i] + 1'b1;
                end
            end
        end
        else
        begin
            prev_next[channel] = cnt;
            age_next[channel]  = '0;
            if (in_window)
            begin
                value_next[channel] = value_db;
                chan_next.accepted  = 1'b1;
            end
        end
        chan_next.accel = (CMP_W'(age_next[0]) > CMP_W'(cfg.timeout_ms)) ? '0 : value_next[0];
        chan_next.steer = (CMP_W'(age_next[1]) > CMP_W'(cfg.timeout_ms)) ? '0 : value_next[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 2; i++)
            begin
                prev_reg[i]  <= '0;
                value_reg[i] <= '0;
                age_reg[i]   <= '0;
            end
        end
        else if (take)
        begin
            for (int i = 0; i < 2; i++)
            begin
                prev_reg[i]  <= prev_next[i];
                value_reg[i] <= value_next[i];
                age_reg[i]   <= age_next[i];
            end
        end
    end

endmodule

FILE: rtl/rcpwm_drive.sv
// Output shaping: limit clamps, drive duty and direction, steering compare.
module rcpwm_drive (
    input  rcpwm_pkg::chan_t chan,
    input  rcpwm_pkg::cfg_t  cfg,
    output rcpwm_pkg::res_t  res
);

    localparam int VW = rcpwm_pkg::VAL_W;

    function automatic logic signed [VW-1:0] clamp_val(input logic signed [VW-1:0] v,
                                                       input logic [9:0] lim);
        logic signed [VW-1:0] l;
        begin
            l = $signed(VW'(lim));
            if (v > l)
            begin
                clamp_val = l;
            end
            else if (v < -l)
            begin
                clamp_val = -l;
            end
            else
            begin
                clamp_val = v;
            end
        end
    endfunction

    logic signed [VW-1:0] accel_c;
    logic signed [VW-1:0] steer_c;
    logic signed [VW-1:0] accel_mag;
    logic signed [12:0]   span;
    logic signed [12:0]   half;
    logic signed [12:0]   cmp;

    always_comb
    begin
        accel_c   = clamp_val(chan.accel, cfg.accel_limit);
        steer_c   = clamp_val(chan.steer, cfg.steer_limit);
        accel_mag = accel_c[VW-1] ? -accel_c : accel_c;
        // 3000 - steer is always positive, so a shift gives the floored half
        span      = 13'sd3000 - 13'(steer_c);
        half      = span >>> 1;
        cmp       = half - $signed(13'(cfg.steer_trim));

        res.drive_duty       = accel_mag[9:0];
        res.drive_reverse    = accel_c[VW-1];
        res.steer_compare    = cmp[12] ? '0 : cmp[10:0];
        res.capture_accepted = chan.accepted;
    end

endmodule

FILE: rtl/rcpwm_skid.sv
// Two-entry output skid buffer with a registered upstream ready.
module rcpwm_skid (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  rcpwm_pkg::res_t in_word,
    output logic            out_valid,
    input  logic            out_ready,
    output rcpwm_pkg::res_t out_word
);

    logic            main_valid_reg;
    logic            skid_valid_reg;
    rcpwm_pkg::res_t main_reg;
    rcpwm_pkg::res_t skid_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_word  = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_ready)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (in_valid)
        begin
            if (!main_valid_reg || out_ready)
            begin
                main_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (out_ready)
        begin
            main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_ready)
            begin
                main_reg <= skid_reg;
            end
        end
        else if (in_valid)
        begin
            if (!main_valid_reg || out_ready)
            begin
                main_reg <= in_word;
            end
            else
            begin
                skid_reg <= in_word;
            end
        end
    end

endmodule

FILE: rtl/rc_pwm_input_to_drive_output.sv
// Top level: config registers, decode stage register and output skid buffer.
//
// Decodes RC receiver pulse captures into a drive duty, direction and a
// steering compare value. Each input word is either a capture event for the
// acceleration or steering channel or a one-millisecond tick; each input
// word yields exactly one result word.
// Input channel: s_tdata holds the capture count, s_tuser the request type
// and channel. Output channel: m_tdata holds duty, reverse, compare and the
// capture-accepted flag. Registers are written through cfg_we/cfg_addr/
// cfg_wdata; the user must write only while the block is idle (not enforced).
// A word passes the decode stage register and the skid buffer main register
// before its result shows on m_tvalid. Throughput: one word per cycle while
// s_tready is high; the channel state update completes in the accept cycle.
// Reset clears the channel state and loads the register defaults.
// When m_tready is low the skid buffer holds up to two results; s_tready
// then drops after one more word, so no result is lost.
module rc_pwm_input_to_drive_output #(
    parameter int COUNTER_BITS = 16,
    parameter int AGE_BITS     = 11
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [15:0] capture_count
    input  logic [1:0]  s_tuser,    // [0] req_type, [1] channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [9:0] drive_duty, [10] drive_reverse,
                                    // [21:11] steer_compare, [22] capture_accepted
    input  logic        cfg_we,
    input  logic [rcpwm_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [rcpwm_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    rcpwm_pkg::cfg_t  cfg_reg;
    rcpwm_pkg::chan_t chan_next;
    rcpwm_pkg::chan_t chan_reg;
    rcpwm_pkg::res_t  res;
    rcpwm_pkg::res_t  out_word;
    logic             stage_valid_reg;
    logic             skid_ready;
    logic             take;
    logic             push;

    assign s_tready = !stage_valid_reg || skid_ready;
    assign take     = s_tvalid && s_tready;
    assign push     = stage_valid_reg && skid_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.capture_wrap <= 16'd65535;
            cfg_reg.accel_offset <= -11'sd65;
            cfg_reg.steer_offset <= -11'sd10;
            cfg_reg.deadband     <= 10'd250;
            cfg_reg.accel_limit  <= 10'd1000;
            cfg_reg.steer_limit  <= 10'd700;
            cfg_reg.timeout_ms   <= 10'd100;
            cfg_reg.steer_trim   <= 10'd200;
        end
        else if (cfg_we)
        begin
            unique case (rcpwm_pkg::cfg_idx_t'(cfg_addr))
                rcpwm_pkg::CFG_CAPTURE_WRAP: cfg_reg.capture_wrap <= cfg_wdata;
                rcpwm_pkg::CFG_ACCEL_OFFSET: cfg_reg.accel_offset <= $signed(cfg_wdata[10:0]);
                rcpwm_pkg::CFG_STEER_OFFSET: cfg_reg.steer_offset <= $signed(cfg_wdata[10:0]);
                rcpwm_pkg::CFG_DEADBAND:     cfg_reg.deadband     <= cfg_wdata[9:0];
                rcpwm_pkg::CFG_ACCEL_LIMIT:  cfg_reg.accel_limit  <= cfg_wdata[9:0];
                rcpwm_pkg::CFG_STEER_LIMIT:  cfg_reg.steer_limit  <= cfg_wdata[9:0];
                rcpwm_pkg::CFG_TIMEOUT_MS:   cfg_reg.timeout_ms   <= cfg_wdata[9:0];
                rcpwm_pkg::CFG_STEER_TRIM:   cfg_reg.steer_trim   <= cfg_wdata[9:0];
            endcase
        end
    end

    rcpwm_decode #(
        .COUNTER_BITS(COUNTER_BITS),
        .AGE_BITS    (AGE_BITS)
    ) u_decode (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .req_type     (s_tuser[0]),
        .channel      (s_tuser[1]),
        .capture_count(s_tdata),
        .cfg          (cfg_reg),
        .chan_next    (chan_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            stage_valid_reg <= 1'b1;
        end
        else if (push)
        begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            chan_reg <= chan_next;
        end
    end

    rcpwm_drive u_drive (
        .chan(chan_reg),
        .cfg (cfg_reg),
        .res (res)
    );

    rcpwm_skid u_skid (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (stage_valid_reg),
        .in_ready (skid_ready),
        .in_word  (res),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_word (out_word)
    );

    assign m_tdata = {1'b0, out_word.capture_accepted, out_word.steer_compare,
                      out_word.drive_reverse, out_word.drive_duty};

endmodule

FILE: bench/rc_pwm_input_to_drive_output_test.sv
// Self-checking testbench for the RC pulse-width decoder with a scoreboard class.
module rc_pwm_input_to_drive_output_test;

    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 150;

    typedef enum int {
        SET_RANDOM,
        SET_LOWEST,
        SET_HIGHEST,
        SET_TYPICAL
    } setting_kind_t;

    // Tracks decoder state and queues the expected result word for every input word.
    class drive_scoreboard;
        rcpwm_pkg::cfg_t    regs;
        logic [15:0]        last_count [2];
        logic signed [11:0] decoded [2];
        logic [10:0]        age [2];
        rcpwm_pkg::res_t    expected_q [$];
        int                 mismatches;

        function new();
            regs.capture_wrap = 16'd65535;
            regs.accel_offset = -11'sd65;
            regs.steer_offset = -11'sd10;
            regs.deadband     = 10'd250;
            regs.accel_limit  = 10'd1000;
            regs.steer_limit  = 10'd700;
            regs.timeout_ms   = 10'd100;
            regs.steer_trim   = 10'd200;
            for (int i = 0; i < 2; i++)
            begin
                last_count[i] = '0;
                decoded[i]    = '0;
                age[i]        = '0;
            end
            mismatches = 0;
        endfunction

        function void set_reg(rcpwm_pkg::cfg_idx_t idx, logic [15:0] val);
            case (idx)
                rcpwm_pkg::CFG_CAPTURE_WRAP: regs.capture_wrap = val;
                rcpwm_pkg::CFG_ACCEL_OFFSET: regs.accel_offset = val[10:0];
                rcpwm_pkg::CFG_STEER_OFFSET: regs.steer_offset = val[10:0];
                rcpwm_pkg::CFG_DEADBAND:     regs.deadband     = val[9:0];
                rcpwm_pkg::CFG_ACCEL_LIMIT:  regs.accel_limit  = val[9:0];
                rcpwm_pkg::CFG_STEER_LIMIT:  regs.steer_limit  = val[9:0];
                rcpwm_pkg::CFG_TIMEOUT_MS:   regs.timeout_ms   = val[9:0];
                rcpwm_pkg::CFG_STEER_TRIM:   regs.steer_trim   = val[9:0];
                default: ;
            endcase
        endfunction

        function int limit_to(int v, int lim);
            if (v > lim)
                return lim;
            if (v < -lim)
                return -lim;
            return v;
        endfunction

        function void note_word(logic [0:0] kind, logic ch, logic [15:0] cnt);
            int              diff;
            int              width;
            int              val;
            int              mag;
            int              offset;
            int              accel;
            int              steer;
            int              cmp;
            logic            hit;
            rcpwm_pkg::res_t want;
            hit = 1'b0;
            if (kind == rcpwm_pkg::REQ_TICK)
            begin
                for (int i = 0; i < 2; i++)
                    if (age[i] != 11'h7FF)
                        age[i] = age[i] + 11'd1;
            end
            else
            begin
                // wrapped difference may go negative when the reload is small
                if (cnt >= last_count[ch])
                    diff = int'(cnt) - int'(last_count[ch]);
                else
                    diff = int'(regs.capture_wrap) - int'(last_count[ch]) + int'(cnt);
                if (ch)
                    offset = regs.steer_offset;
                else
                    offset = regs.accel_offset;
                width = diff - offset;
                if (width > 850 && width < 2150)
                begin
                    val = 2 * (width - 1500);
                    mag = (val < 0) ? -val : val;
                    if (mag < int'(regs.deadband))
                        val = 0;
                    decoded[ch] = val[11:0];
                    hit = 1'b1;
                end
                last_count[ch] = cnt;
                age[ch] = '0;
            end
            accel = decoded[0];
            if (age[0] > regs.timeout_ms)
                accel = 0;
            steer = decoded[1];
            if (age[1] > regs.timeout_ms)
                steer = 0;
            accel = limit_to(accel, int'(regs.accel_limit));
            steer = limit_to(steer, int'(regs.steer_limit));
            cmp = (3000 - steer) / 2 - int'(regs.steer_trim);
            if (cmp < 0)
                cmp = 0;
            want.drive_duty       = 10'((accel < 0) ? -accel : accel);
            want.drive_reverse    = (accel < 0);
            want.steer_compare    = cmp[10:0];
            want.capture_accepted = hit;
            expected_q.push_back(want);
        endfunction

        function void check_result(logic [23:0] word);
            rcpwm_pkg::res_t got;
            rcpwm_pkg::res_t want;
            got = word[22:0];
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result word %h with nothing expected", word);
                return;
            end
            want = expected_q.pop_front();
            if (got.drive_duty !== want.drive_duty || got.drive_reverse !== want.drive_reverse
                || got.steer_compare !== want.steer_compare
                || got.capture_accepted !== want.capture_accepted)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp duty=%0d rev=%0d cmp=%0d acc=%0d,",
                             want.drive_duty, want.drive_reverse, want.steer_compare,
                             want.capture_accepted,
                             " got duty=%0d rev=%0d cmp=%0d acc=%0d",
                             got.drive_duty, got.drive_reverse,
                             got.steer_compare, got.capture_accepted);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [15:0]                      s_tdata = '0;
    logic [1:0]                       s_tuser = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [23:0]                      m_tdata;
    logic                             cfg_we = 1'b0;
    logic [rcpwm_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [rcpwm_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    drive_scoreboard sb = new();

    // sender-side view of the channel state, used to aim captures at a width
    logic [15:0] stim_prev [2] = '{16'd0, 16'd0};
    int          stim_off [2] = '{-65, -10};
    int          stim_wrap = 65535;
    int          stim_timeout = 100;
    int          burst_left = 20;
    bit          hold_req = 1'b0;
    int          idle_cycles = 0;

    rc_pwm_input_to_drive_output dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // monitor and watchdog
    always @(posedge clk)
    begin
        if (cfg_we)
            sb.set_reg(rcpwm_pkg::cfg_idx_t'(cfg_addr), cfg_wdata);
        if (s_tvalid && s_tready)
            sb.note_word(s_tuser[0], s_tuser[1], s_tdata);
        if (m_tvalid && m_tready)
            sb.check_result(m_tdata);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("rc_pwm_input_to_drive_output_test failed");
            $finish;
        end
    end

    // receiver: random ready patterns, plus a long hold-off on request
    initial
    begin
        int mode;
        int left;
        mode = 0;
        left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                if (left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(20, 300);
                end
                left--;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 4) != 0);
                    default: m_tready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    task automatic send_word(logic [0:0] kind, logic ch, logic [15:0] cnt);
        s_tvalid <= 1'b1;
        s_tdata  <= cnt;
        s_tuser  <= {ch, kind};
        do
            @(posedge clk);
        while (!s_tready);
        if (kind == rcpwm_pkg::REQ_CAPTURE)
            stim_prev[ch] = cnt;
        burst_left--;
        if (burst_left <= 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 120 : $urandom_range(1, 30);
        end
    endtask

    // capture whose measured width (after offset) comes out as the given value
    task automatic send_width(logic ch, int width);
        int          d;
        int          prev;
        int          c1;
        int          c2;
        logic [15:0] cnt;
        prev = stim_prev[ch];
        d  = width + stim_off[ch];
        c1 = prev + d;
        c2 = prev + d - stim_wrap;
        if (d >= 0 && c1 <= 65535)
            cnt = c1[15:0];
        else if (c2 >= 0 && c2 < prev)
            cnt = c2[15:0];
        else
            cnt = c1[15:0];
        send_word(rcpwm_pkg::REQ_CAPTURE, ch, cnt);
    endtask

    task automatic send_tick();
        send_word(rcpwm_pkg::REQ_TICK, 1'($urandom_range(0, 1)), 16'($urandom));
    endtask

    task automatic drain();
        if (s_tvalid)
            s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic put_reg(rcpwm_pkg::cfg_idx_t idx, logic [15:0] val, int w);
        logic [15:0] mask;
        logic [15:0] junk;
        mask = (w >= 16) ? 16'hFFFF : ((16'h1 << w) - 16'h1);
        junk = 16'($urandom);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= (val & mask) | (junk & ~mask);
        @(posedge clk);
    endtask

    task automatic apply_config(rcpwm_pkg::cfg_t c);
        put_reg(rcpwm_pkg::CFG_CAPTURE_WRAP, c.capture_wrap, 16);
        put_reg(rcpwm_pkg::CFG_ACCEL_OFFSET, 16'(c.accel_offset), 11);
        put_reg(rcpwm_pkg::CFG_STEER_OFFSET, 16'(c.steer_offset), 11);
        put_reg(rcpwm_pkg::CFG_DEADBAND, 16'(c.deadband), 10);
        put_reg(rcpwm_pkg::CFG_ACCEL_LIMIT, 16'(c.accel_limit), 10);
        put_reg(rcpwm_pkg::CFG_STEER_LIMIT, 16'(c.steer_limit), 10);
        put_reg(rcpwm_pkg::CFG_TIMEOUT_MS, 16'(c.timeout_ms), 10);
        put_reg(rcpwm_pkg::CFG_STEER_TRIM, 16'(c.steer_trim), 10);
        cfg_we <= 1'b0;
        stim_wrap    = c.capture_wrap;
        stim_off[0]  = c.accel_offset;
        stim_off[1]  = c.steer_offset;
        stim_timeout = c.timeout_ms;
    endtask

    function automatic rcpwm_pkg::cfg_t make_config(setting_kind_t kind);
        rcpwm_pkg::cfg_t c;
        int              off_a;
        int              off_s;
        case (kind)
            SET_LOWEST:
            begin
                c = '0;
                c.accel_offset = -11'sd1024;
                c.steer_offset = -11'sd1024;
            end
            SET_HIGHEST:
            begin
                c.capture_wrap = 16'hFFFF;
                c.accel_offset = 11'sd1023;
                c.steer_offset = 11'sd1023;
                c.deadband     = 10'd1023;
                c.accel_limit  = 10'd1023;
                c.steer_limit  = 10'd1023;
                c.timeout_ms   = 10'd1023;
                c.steer_trim   = 10'd1023;
            end
            SET_TYPICAL:
            begin
                off_a = int'($urandom_range(0, 200)) - 100;
                off_s = int'($urandom_range(0, 200)) - 100;
                c.capture_wrap = ($urandom_range(0, 1) != 0) ? 16'hFFFF
                                 : 16'($urandom_range(40000, 65535));
                c.accel_offset = off_a[10:0];
                c.steer_offset = off_s[10:0];
                c.deadband     = 10'($urandom_range(0, 300));
                c.accel_limit  = 10'($urandom_range(500, 1023));
                c.steer_limit  = 10'($urandom_range(300, 1023));
                c.timeout_ms   = 10'($urandom_range(2, 20));
                c.steer_trim   = 10'($urandom_range(0, 400));
            end
            default:
            begin
                c.capture_wrap = 16'($urandom);
                c.accel_offset = 11'($urandom);
                c.steer_offset = 11'($urandom);
                c.deadband     = 10'($urandom);
                c.accel_limit  = 10'($urandom);
                c.steer_limit  = 10'($urandom);
                c.timeout_ms   = 10'($urandom);
                c.steer_trim   = 10'($urandom);
            end
        endcase
        return c;
    endfunction

    task automatic random_item();
        int   r;
        int   n;
        int   width;
        logic ch;
        r  = $urandom_range(0, 99);
        ch = 1'($urandom_range(0, 1));
        if (r < 15)
        begin
            n = $urandom_range(1, 4);
            // occasionally tick just past the timeout
            if ($urandom_range(0, 9) == 0 && stim_timeout < 60)
                n = stim_timeout + 1 + $urandom_range(0, 1);
            repeat (n) send_tick();
        end
        else if (r < 85)
        begin
            case ($urandom_range(0, 9))
                0:
                    case ($urandom_range(0, 5))
                        0: width = 849;
                        1: width = 850;
                        2: width = 851;
                        3: width = 2149;
                        4: width = 2150;
                        default: width = 2151;
                    endcase
                1: width = $urandom_range(0, 3000);
                default: width = $urandom_range(860, 2140);
            endcase
            send_width(ch, width);
        end
        else
            send_word(rcpwm_pkg::REQ_CAPTURE, ch, 16'($urandom));
    endtask

    initial
    begin
        rcpwm_pkg::cfg_t c;
        setting_kind_t   plan [8];
        plan = '{SET_TYPICAL, SET_RANDOM, SET_LOWEST, SET_TYPICAL,
                 SET_HIGHEST, SET_RANDOM, SET_TYPICAL, SET_TYPICAL};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: window edges, deadband edge, clamps, wrap
        send_word(rcpwm_pkg::REQ_CAPTURE, 1'b0, 16'h0000);
        send_word(rcpwm_pkg::REQ_CAPTURE, 1'b1, 16'hFFFF);
        send_width(1'b0, 1500);
        send_width(1'b0, 2000);
        send_width(1'b0, 850);
        send_width(1'b0, 2150);
        send_width(1'b0, 851);
        send_width(1'b0, 2149);
        send_width(1'b0, 1624);
        send_width(1'b0, 1625);
        send_width(1'b1, 1849);
        send_width(1'b1, 1851);
        send_width(1'b1, 1100);
        send_word(rcpwm_pkg::REQ_CAPTURE, 1'b0, 16'hFF00);
        send_width(1'b0, 1700);
        send_tick();
        send_tick();
        send_width(1'b1, 1500);
        drain();

        // small reload, zero timeout, odd steering limit, trim past the compare
        c.capture_wrap = 16'd100;
        c.accel_offset = 11'sd1000;
        c.steer_offset = -11'sd1000;
        c.deadband     = 10'd0;
        c.accel_limit  = 10'd0;
        c.steer_limit  = 10'd1023;
        c.timeout_ms   = 10'd0;
        c.steer_trim   = 10'd1023;
        apply_config(c);
        send_tick();
        send_width(1'b0, -5);
        send_width(1'b1, 2149);
        send_width(1'b1, 851);
        send_width(1'b0, 2000);
        send_word(rcpwm_pkg::REQ_CAPTURE, 1'b0, 16'hF000);
        send_word(rcpwm_pkg::REQ_CAPTURE, 1'b0, 16'h0010);
        send_tick();

        foreach (plan[p])
        begin
            drain();
            apply_config(make_config(plan[p]));
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (k == PHASE_ITEMS / 2)
                    hold_req = 1'b1;
                random_item();
            end
        end
        drain();

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("rc_pwm_input_to_drive_output_test passed");
        else
            $display("rc_pwm_input_to_drive_output_test failed");
        $finish;
    end

endmodule
